// ===== rtl/core/raim_pkg.sv =====
// Shared types and codes for the range attribute interval map.
package raim_pkg;

  localparam int unsigned FLAG_BITS = 16;
  localparam int unsigned ADDR_BITS = 64;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [FLAG_BITS-1:0] flags_t;

  typedef enum logic [2:0] {
    OP_SET      = 3'd0,
    OP_CLEAR    = 3'd1,
    OP_TEST     = 3'd2,
    OP_FIND     = 3'd3,
    OP_SET_PRIV = 3'd4,
    OP_GET_PRIV = 3'd5
  } op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_MATCH = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    addr_t  iv_start;
    addr_t  iv_end;
    flags_t iv_flags;
    addr_t  iv_priv;
  } entry_t;

  typedef struct packed {
    logic [2:0] req_type;
    addr_t      range_start;
    addr_t      range_end;
    flags_t     flag_mask;
    logic       need_full;
    addr_t      private_in;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       hit;
    addr_t      found_start;
    addr_t      found_end;
    flags_t     cleared_flags;
    addr_t      private_out;
  } res_t;

endpackage

// ===== rtl/core/raim_if.sv =====
// Request and result channel interfaces of the range attribute interval map.
interface raim_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [63:0] range_start;
  logic [63:0] range_end;
  logic [15:0] flag_mask;
  logic        need_full;
  logic [63:0] private_in;

  modport source (output valid, req_type, range_start, range_end, flag_mask, need_full,
                  private_in, input ready);
  modport sink (input valid, req_type, range_start, range_end, flag_mask, need_full,
                private_in, output ready);
endinterface

interface raim_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        hit;
  logic [63:0] found_start;
  logic [63:0] found_end;
  logic [15:0] cleared_flags;
  logic [63:0] private_out;

  modport source (output valid, status, hit, found_start, found_end, cleared_flags,
                  private_out, input ready);
  modport sink (input valid, status, hit, found_start, found_end, cleared_flags,
                private_out, output ready);
endinterface

// ===== rtl/core/raim_ram.sv =====
// Interval table memory with one write port and one registered read port.
module raim_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  raim_pkg::entry_t      wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output raim_pkg::entry_t      rdata
);

  raim_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/raim_engine.sv =====
// Request sequencer that walks, splits, inserts, merges and drops table entries.
module raim_engine #(
  parameter int unsigned MAX_INTERVALS = 64,
  parameter int unsigned AW = 6,
  parameter int unsigned IW = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  output logic                req_ready,
  input  raim_pkg::req_t      req,
  output logic                res_valid,
  input  logic                res_ready,
  output raim_pkg::res_t      res,
  input  raim_pkg::flags_t    no_merge_mask,
  output logic                mem_we,
  output logic [AW-1:0]       mem_wa,
  output raim_pkg::entry_t    mem_wd,
  output logic                mem_re,
  output logic [AW-1:0]       mem_ra,
  input  raim_pkg::entry_t    mem_rd
);

  typedef enum logic [18:0] {
    S_IDLE   = 19'd1 << 0,
    S_LOC_RD = 19'd1 << 1,
    S_LOC_CK = 19'd1 << 2,
    S_NXT_RD = 19'd1 << 3,
    S_NXT_LD = 19'd1 << 4,
    S_DISP   = 19'd1 << 5,
    S_INS    = 19'd1 << 6,
    S_SHD    = 19'd1 << 7,
    S_INS_W  = 19'd1 << 8,
    S_INS_W2 = 19'd1 << 9,
    S_J0     = 19'd1 << 10,
    S_J1     = 19'd1 << 11,
    S_J2     = 19'd1 << 12,
    S_J3     = 19'd1 << 13,
    S_DRP0   = 19'd1 << 14,
    S_DRP    = 19'd1 << 15,
    S_STRIP  = 19'd1 << 16,
    S_CONT   = 19'd1 << 17,
    S_DONE   = 19'd1 << 18
  } state_t;

  state_t st_r, st_nxt, after_r, after_nxt, dret_r, dret_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt, i_r, i_nxt, pos_r, pos_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [2:0] op_r, op_nxt;
  raim_pkg::addr_t s_r, s_nxt, e_r, e_nxt, pin_r, pin_nxt;
  raim_pkg::flags_t bits_r, bits_nxt, gone_r, gone_nxt;
  logic full_r, full_nxt, two_r, two_nxt, fin_r, fin_nxt, hit_r, hit_nxt;
  logic [1:0] status_r, status_nxt;
  raim_pkg::addr_t fs_r, fs_nxt, fe_r, fe_nxt, pv_r, pv_nxt;
  raim_pkg::entry_t cur_r, cur_nxt, lo_r, lo_nxt, hi_r, hi_nxt, w_r, w_nxt;

  raim_pkg::addr_t ls, le, s_m1, e_p1, le_p1, ls_m1, te;
  raim_pkg::flags_t cf, nf;
  logic at_end;
  logic [IW-1:0] lb;

  assign ls     = cur_r.iv_start;
  assign le     = cur_r.iv_end;
  assign cf     = cur_r.iv_flags;
  assign s_m1   = s_r - 64'd1;
  assign e_p1   = e_r + 64'd1;
  assign le_p1  = le + 64'd1;
  assign ls_m1  = ls - 64'd1;
  assign te     = (e_r < ls) ? e_r : ls_m1;
  assign at_end = (i_r == cnt_r);
  assign lb     = pos_r + IW'(1) + IW'(two_r);
  assign nf     = w_r.iv_flags & ~bits_r;

  assign res = '{status: status_r, hit: hit_r, found_start: fs_r, found_end: fe_r,
                 cleared_flags: gone_r, private_out: pv_r};

  always_comb begin
    st_nxt = st_r;  after_nxt = after_r;  dret_nxt = dret_r;
    cnt_nxt = cnt_r;  i_nxt = i_r;  pos_nxt = pos_r;  j_nxt = j_r;  k_nxt = k_r;
    op_nxt = op_r;  s_nxt = s_r;  e_nxt = e_r;  pin_nxt = pin_r;
    bits_nxt = bits_r;  gone_nxt = gone_r;  full_nxt = full_r;  two_nxt = two_r;
    fin_nxt = fin_r;  hit_nxt = hit_r;  status_nxt = status_r;
    fs_nxt = fs_r;  fe_nxt = fe_r;  pv_nxt = pv_r;
    cur_nxt = cur_r;  lo_nxt = lo_r;  hi_nxt = hi_r;  w_nxt = w_r;
    mem_we = 1'b0;  mem_wa = '0;  mem_wd = w_r;
    mem_re = 1'b0;  mem_ra = '0;
    req_ready = 1'b0;  res_valid = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          op_nxt = req.req_type;  s_nxt = req.range_start;  e_nxt = req.range_end;
          bits_nxt = req.flag_mask;  full_nxt = req.need_full;  pin_nxt = req.private_in;
          status_nxt = raim_pkg::ST_OK;  hit_nxt = 1'b0;  fs_nxt = '0;  fe_nxt = '0;
          gone_nxt = '0;  pv_nxt = '0;  i_nxt = '0;
          if (req.req_type > raim_pkg::OP_GET_PRIV) begin
            st_nxt = S_DONE;
          end else if ((req.req_type == raim_pkg::OP_SET ||
                        req.req_type == raim_pkg::OP_CLEAR) &&
                       req.range_end < req.range_start) begin
            st_nxt = S_DONE;
          end else begin
            st_nxt = S_LOC_RD;
          end
        end
      end
      S_LOC_RD, S_NXT_RD: begin
        if (at_end) begin
          st_nxt = S_DISP;
        end else begin
          mem_re = 1'b1;
          mem_ra = i_r[AW-1:0];
          st_nxt = (st_r == S_LOC_RD) ? S_LOC_CK : S_NXT_LD;
        end
      end
      S_LOC_CK: begin
        if (mem_rd.iv_end >= s_r) begin
          cur_nxt = mem_rd;
          st_nxt = S_DISP;
        end else begin
          i_nxt = i_r + IW'(1);
          st_nxt = S_LOC_RD;
        end
      end
      S_NXT_LD: begin
        cur_nxt = mem_rd;
        st_nxt = S_DISP;
      end
      S_DISP: begin
        case (op_r)
          raim_pkg::OP_SET: begin
            pos_nxt = i_r;
            st_nxt = S_INS;
            if (at_end) begin
              two_nxt = 1'b0;
              lo_nxt = '{s_r, e_r, bits_r, 64'd0};
              w_nxt = '{s_r, e_r, bits_r, 64'd0};
              j_nxt = i_r;  after_nxt = S_J0;  fin_nxt = 1'b1;
            end else if (ls == s_r && le <= e_r) begin
              w_nxt = '{ls, le, cf | bits_r, cur_r.iv_priv};
              mem_we = 1'b1;
              mem_wa = i_r[AW-1:0];
              mem_wd = '{ls, le, cf | bits_r, cur_r.iv_priv};
              j_nxt = i_r;  fin_nxt = (le >= e_r);  s_nxt = le_p1;
              st_nxt = S_J0;
            end else if (ls < s_r) begin
              two_nxt = 1'b1;
              lo_nxt = '{ls, s_m1, cf, 64'd0};
              if (le <= e_r) begin
                hi_nxt = '{s_r, le, cf | bits_r, cur_r.iv_priv};
                w_nxt = '{s_r, le, cf | bits_r, cur_r.iv_priv};
                j_nxt = i_r + IW'(1);  after_nxt = S_J0;
                fin_nxt = (le >= e_r);  s_nxt = le_p1;
              end else begin
                hi_nxt = '{s_r, le, cf, cur_r.iv_priv};
                after_nxt = S_CONT;  fin_nxt = 1'b0;
              end
            end else if (ls > s_r) begin
              two_nxt = 1'b0;
              lo_nxt = '{s_r, te, bits_r, 64'd0};
              w_nxt = '{s_r, te, bits_r, 64'd0};
              j_nxt = i_r;  after_nxt = S_J0;
              fin_nxt = (e_r < ls);
              s_nxt = (e_r < ls) ? e_p1 : ls;
            end else begin
              two_nxt = 1'b1;
              lo_nxt = '{ls, e_r, cf | bits_r, 64'd0};
              hi_nxt = '{e_p1, le, cf, cur_r.iv_priv};
              w_nxt = '{ls, e_r, cf | bits_r, 64'd0};
              j_nxt = i_r;  after_nxt = S_J0;  fin_nxt = 1'b1;
            end
          end
          raim_pkg::OP_CLEAR: begin
            pos_nxt = i_r;
            if (at_end || ls > e_r) begin
              st_nxt = S_DONE;
            end else if (ls < s_r) begin
              two_nxt = 1'b1;
              lo_nxt = '{ls, s_m1, cf, 64'd0};
              hi_nxt = '{s_r, le, cf, cur_r.iv_priv};
              if (le <= e_r) begin
                w_nxt = '{s_r, le, cf, cur_r.iv_priv};
                j_nxt = i_r + IW'(1);  after_nxt = S_STRIP;
                fin_nxt = (le >= e_r);  s_nxt = le_p1;
              end else begin
                after_nxt = S_CONT;  fin_nxt = 1'b0;
              end
              st_nxt = S_INS;
            end else if (le > e_r) begin
              two_nxt = 1'b1;
              lo_nxt = '{ls, e_r, cf, 64'd0};
              hi_nxt = '{e_p1, le, cf, cur_r.iv_priv};
              w_nxt = '{ls, e_r, cf, 64'd0};
              j_nxt = i_r;  after_nxt = S_STRIP;  fin_nxt = 1'b1;
              st_nxt = S_INS;
            end else begin
              w_nxt = cur_r;
              j_nxt = i_r;  fin_nxt = (le >= e_r);  s_nxt = le_p1;
              st_nxt = S_STRIP;
            end
          end
          raim_pkg::OP_TEST: begin
            st_nxt = S_DONE;
            if (at_end) begin
              hit_nxt = full_r ? 1'b0 : hit_r;
            end else if (s_r > e_r) begin
              hit_nxt = hit_r;
            end else if (full_r && ls > s_r) begin
              hit_nxt = 1'b0;
            end else if (ls > e_r) begin
              hit_nxt = hit_r;
            end else if ((cf & bits_r) != '0 && !full_r) begin
              hit_nxt = 1'b1;
            end else if ((cf & bits_r) == '0 && full_r) begin
              hit_nxt = 1'b0;
            end else begin
              if ((cf & bits_r) != '0) begin
                hit_nxt = 1'b1;
              end
              if (le < e_r) begin
                s_nxt = le_p1;
                i_nxt = i_r + IW'(1);
                st_nxt = S_NXT_RD;
              end
            end
          end
          raim_pkg::OP_FIND: begin
            st_nxt = S_DONE;
            if (at_end) begin
              status_nxt = raim_pkg::ST_NO_MATCH;
            end else if ((cf & bits_r) != '0) begin
              hit_nxt = 1'b1;  fs_nxt = ls;  fe_nxt = le;
            end else begin
              i_nxt = i_r + IW'(1);
              st_nxt = S_NXT_RD;
            end
          end
          raim_pkg::OP_SET_PRIV, raim_pkg::OP_GET_PRIV: begin
            st_nxt = S_DONE;
            if (at_end || ls != s_r) begin
              status_nxt = raim_pkg::ST_NO_MATCH;
            end else if (op_r == raim_pkg::OP_SET_PRIV) begin
              mem_we = 1'b1;
              mem_wa = i_r[AW-1:0];
              mem_wd = '{ls, le, cf, pin_r};
            end else begin
              pv_nxt = cur_r.iv_priv;
            end
          end
          default: st_nxt = S_DONE;
        endcase
      end
      S_INS: begin
        if (cnt_r == IW'(MAX_INTERVALS)) begin
          status_nxt = raim_pkg::ST_FULL;
          st_nxt = S_DONE;
        end else if (cnt_r < lb) begin
          st_nxt = S_INS_W;
        end else begin
          mem_re = 1'b1;
          mem_ra = AW'(cnt_r - IW'(1));
          k_nxt = cnt_r;
          st_nxt = S_SHD;
        end
      end
      S_SHD: begin
        mem_we = 1'b1;
        mem_wa = k_r[AW-1:0];
        mem_wd = mem_rd;
        if (k_r == lb) begin
          st_nxt = S_INS_W;
        end else begin
          mem_re = 1'b1;
          mem_ra = AW'(k_r - IW'(2));
          k_nxt = k_r - IW'(1);
        end
      end
      S_INS_W: begin
        cnt_nxt = cnt_r + IW'(1);
        mem_we = 1'b1;
        mem_wa = pos_r[AW-1:0];
        mem_wd = lo_r;
        st_nxt = two_r ? S_INS_W2 : after_r;
      end
      S_INS_W2: begin
        mem_we = 1'b1;
        mem_wa = AW'(pos_r + IW'(1));
        mem_wd = hi_r;
        st_nxt = after_r;
      end
      S_J0: begin
        if ((w_r.iv_flags & no_merge_mask) != '0) begin
          st_nxt = S_CONT;
        end else if (j_r != '0) begin
          mem_re = 1'b1;
          mem_ra = AW'(j_r - IW'(1));
          st_nxt = S_J1;
        end else begin
          st_nxt = S_J2;
        end
      end
      S_J1: begin
        if (mem_rd.iv_end == w_r.iv_start - 64'd1 && mem_rd.iv_flags == w_r.iv_flags) begin
          w_nxt.iv_start = mem_rd.iv_start;
          mem_we = 1'b1;
          mem_wa = AW'(j_r - IW'(1));
          mem_wd = '{mem_rd.iv_start, w_r.iv_end, w_r.iv_flags, w_r.iv_priv};
          pos_nxt = j_r;
          j_nxt = j_r - IW'(1);
          dret_nxt = S_J2;
          st_nxt = S_DRP0;
        end else begin
          st_nxt = S_J2;
        end
      end
      S_J2: begin
        if (j_r + IW'(1) < cnt_r) begin
          mem_re = 1'b1;
          mem_ra = AW'(j_r + IW'(1));
          st_nxt = S_J3;
        end else begin
          st_nxt = S_CONT;
        end
      end
      S_J3: begin
        if (mem_rd.iv_start == w_r.iv_end + 64'd1 && mem_rd.iv_flags == w_r.iv_flags) begin
          mem_we = 1'b1;
          mem_wa = AW'(j_r + IW'(1));
          mem_wd = '{w_r.iv_start, mem_rd.iv_end, mem_rd.iv_flags, mem_rd.iv_priv};
          pos_nxt = j_r;
          dret_nxt = S_CONT;
          st_nxt = S_DRP0;
        end else begin
          st_nxt = S_CONT;
        end
      end
      S_DRP0: begin
        if (pos_r + IW'(1) >= cnt_r) begin
          cnt_nxt = cnt_r - IW'(1);
          st_nxt = dret_r;
        end else begin
          mem_re = 1'b1;
          mem_ra = AW'(pos_r + IW'(1));
          k_nxt = pos_r;
          st_nxt = S_DRP;
        end
      end
      S_DRP: begin
        mem_we = 1'b1;
        mem_wa = k_r[AW-1:0];
        mem_wd = mem_rd;
        if (k_r + IW'(2) == cnt_r) begin
          cnt_nxt = cnt_r - IW'(1);
          st_nxt = dret_r;
        end else begin
          mem_re = 1'b1;
          mem_ra = AW'(k_r + IW'(2));
          k_nxt = k_r + IW'(1);
        end
      end
      S_STRIP: begin
        gone_nxt = gone_r | (w_r.iv_flags & bits_r);
        if (nf == '0) begin
          pos_nxt = j_r;
          dret_nxt = S_CONT;
          st_nxt = S_DRP0;
        end else begin
          w_nxt.iv_flags = nf;
          mem_we = 1'b1;
          mem_wa = j_r[AW-1:0];
          mem_wd = '{w_r.iv_start, w_r.iv_end, nf, w_r.iv_priv};
          st_nxt = S_J0;
        end
      end
      S_CONT: begin
        if (fin_r) begin
          st_nxt = S_DONE;
        end else begin
          i_nxt = '0;
          st_nxt = S_LOC_RD;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    after_r <= after_nxt;  dret_r <= dret_nxt;
    i_r <= i_nxt;  pos_r <= pos_nxt;  j_r <= j_nxt;  k_r <= k_nxt;
    op_r <= op_nxt;  s_r <= s_nxt;  e_r <= e_nxt;  pin_r <= pin_nxt;
    bits_r <= bits_nxt;  gone_r <= gone_nxt;  full_r <= full_nxt;  two_r <= two_nxt;
    fin_r <= fin_nxt;  hit_r <= hit_nxt;  status_r <= status_nxt;
    fs_r <= fs_nxt;  fe_r <= fe_nxt;  pv_r <= pv_nxt;
    cur_r <= cur_nxt;  lo_r <= lo_nxt;  hi_r <= hi_nxt;  w_r <= w_nxt;
  end

endmodule

// ===== rtl/core/range_attribute_interval_map_core.sv =====
// Top level of the range attribute interval map: channels, register, table and sequencer.
// Every lookup scans the table from entry 0, one entry at a time, through the single read
// port of the table memory. Set and clear repeat that scan for each interval they touch
// and shift the following entries one at a time on each insertion, merge or removal,
// up to n entries per move for n stored intervals.
// Reset clears the entry count and the register; table contents are not cleared.
module range_attribute_interval_map_core #(
  parameter int unsigned MAX_INTERVALS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  raim_in_if.sink       in_ch,
  raim_out_if.source    out_ch,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata
);

  localparam int unsigned AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int unsigned IW = $clog2(MAX_INTERVALS + 1);

  raim_pkg::flags_t nm_r;
  logic             out_valid_r;
  raim_pkg::res_t   out_r;
  raim_pkg::req_t   req;
  raim_pkg::res_t   res;
  logic             res_valid, res_ready;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_wa, mem_ra;
  raim_pkg::entry_t mem_wd, mem_rd;

  assign req = '{req_type: in_ch.req_type, range_start: in_ch.range_start,
                 range_end: in_ch.range_end, flag_mask: in_ch.flag_mask,
                 need_full: in_ch.need_full, private_in: in_ch.private_in};

  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        nm_r <= cfg_wdata;
      end
      if (res_ready) begin
        out_valid_r <= res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_r.status;
  assign out_ch.hit           = out_r.hit;
  assign out_ch.found_start   = out_r.found_start;
  assign out_ch.found_end     = out_r.found_end;
  assign out_ch.cleared_flags = out_r.cleared_flags;
  assign out_ch.private_out   = out_r.private_out;

  raim_engine #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .AW            (AW),
    .IW            (IW)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (in_ch.valid),
    .req_ready     (in_ch.ready),
    .req           (req),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .no_merge_mask (nm_r),
    .mem_we        (mem_we),
    .mem_wa        (mem_wa),
    .mem_wd        (mem_wd),
    .mem_re        (mem_re),
    .mem_ra        (mem_ra),
    .mem_rd        (mem_rd)
  );

  raim_ram #(
    .DEPTH (MAX_INTERVALS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (mem_wd),
    .re    (mem_re),
    .raddr (mem_ra),
    .rdata (mem_rd)
  );

endmodule

// ===== rtl/core/raim_checker.sv =====
// Port-level checks of the range attribute interval map and their binding.
module raim_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic        out_hit,
  input logic [63:0] out_found_start,
  input logic [63:0] out_found_end,
  input logic [15:0] out_cleared_flags,
  input logic [63:0] out_private_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_private_out) && $stable(out_found_start))
    else $error("result word changed while stalled");

  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_status == raim_pkg::ST_OK)
    else $error("hit reported with a failing status");

  a_found_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_found_start <= out_found_end)
    else $error("found interval is reversed");

  a_priv_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_private_out != 64'd0 |->
    out_status == raim_pkg::ST_OK && !out_hit && out_cleared_flags == 16'd0)
    else $error("private value returned together with other results");

endmodule

bind range_attribute_interval_map_core raim_checker u_raim_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_hit           (out_ch.hit),
  .out_found_start   (out_ch.found_start),
  .out_found_end     (out_ch.found_end),
  .out_cleared_flags (out_ch.cleared_flags),
  .out_private_out   (out_ch.private_out)
);

// ===== tb/range_attribute_interval_map_checker.sv =====
// Checker that predicts every result word of the interval map and compares it with the block.
module range_attribute_interval_map_checker
  import raim_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  raim_in_if          in_ch,
  raim_out_if         out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 64;
  localparam addr_t ADDR_TOP = '1;

  addr_t  tbl_start [TABLE_DEPTH];
  addr_t  tbl_end   [TABLE_DEPTH];
  flags_t tbl_flags [TABLE_DEPTH];
  addr_t  tbl_priv  [TABLE_DEPTH];
  int     tbl_count;
  flags_t merge_block;

  res_t   expected_words [$];
  int     mismatches;

  function automatic int find_slot(addr_t a);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_end[i] >= a) return i;
    end
    return tbl_count;
  endfunction

  function automatic bit insert_entry(int pos, addr_t s, addr_t e, flags_t f, addr_t p);
    if (tbl_count >= TABLE_DEPTH || pos > tbl_count) return 0;
    for (int k = tbl_count; k > pos; k--) begin
      tbl_start[k] = tbl_start[k-1];
      tbl_end[k]   = tbl_end[k-1];
      tbl_flags[k] = tbl_flags[k-1];
      tbl_priv[k]  = tbl_priv[k-1];
    end
    tbl_start[pos] = s;
    tbl_end[pos]   = e;
    tbl_flags[pos] = f;
    tbl_priv[pos]  = p;
    tbl_count++;
    return 1;
  endfunction

  function automatic void remove_entry(int pos);
    if (pos >= tbl_count) return;
    for (int k = pos; k + 1 < tbl_count; k++) begin
      tbl_start[k] = tbl_start[k+1];
      tbl_end[k]   = tbl_end[k+1];
      tbl_flags[k] = tbl_flags[k+1];
      tbl_priv[k]  = tbl_priv[k+1];
    end
    tbl_count--;
  endfunction

  function automatic void merge_around(int idx);
    int i;
    i = idx;
    if (i >= tbl_count || (tbl_flags[i] & merge_block) != 0) return;
    if (i > 0 && tbl_end[i-1] == tbl_start[i] - 64'd1 && tbl_flags[i-1] == tbl_flags[i]) begin
      tbl_start[i] = tbl_start[i-1];
      remove_entry(i - 1);
      i--;
    end
    if (i + 1 < tbl_count && tbl_start[i+1] == tbl_end[i] + 64'd1 &&
        tbl_flags[i+1] == tbl_flags[i]) begin
      tbl_start[i+1] = tbl_start[i];
      remove_entry(i);
    end
  endfunction

  function automatic bit split_entry(int i, addr_t at);
    if (!insert_entry(i, tbl_start[i], at - 64'd1, tbl_flags[i], '0)) return 0;
    tbl_start[i+1] = at;
    return 1;
  endfunction

  function automatic logic [1:0] set_range(addr_t s_in, addr_t e, flags_t b);
    int i;
    addr_t s, ls, le, te;
    s = s_in;
    while (1) begin
      i = find_slot(s);
      if (i == tbl_count) begin
        if (!insert_entry(i, s, e, b, '0)) return ST_FULL;
        merge_around(i);
        return ST_OK;
      end
      ls = tbl_start[i];
      le = tbl_end[i];
      if (ls == s && le <= e) begin
        tbl_flags[i] |= b;
        merge_around(i);
        if (le == ADDR_TOP) return ST_OK;
        s = le + 64'd1;
      end else if (ls < s) begin
        if (!split_entry(i, s)) return ST_FULL;
        if (le <= e) begin
          tbl_flags[i+1] |= b;
          merge_around(i + 1);
          if (le == ADDR_TOP) return ST_OK;
          s = le + 64'd1;
        end
      end else if (ls > s) begin
        te = (e < ls) ? e : ls - 64'd1;
        if (!insert_entry(i, s, te, b, '0)) return ST_FULL;
        merge_around(i);
        s = te + 64'd1;
      end else begin
        if (!split_entry(i, e + 64'd1)) return ST_FULL;
        tbl_flags[i] |= b;
        merge_around(i);
        return ST_OK;
      end
      if (s > e) return ST_OK;
    end
    return ST_OK;
  endfunction

  function automatic flags_t strip_entry(int i, flags_t b);
    flags_t r;
    r = tbl_flags[i] & b;
    tbl_flags[i] &= ~b;
    if (tbl_flags[i] == '0) remove_entry(i);
    else merge_around(i);
    return r;
  endfunction

  function automatic logic [1:0] clear_range(addr_t s_in, addr_t e, flags_t b,
                                             inout flags_t gone);
    int i;
    addr_t s, le;
    s = s_in;
    while (1) begin
      i = find_slot(s);
      if (i == tbl_count || tbl_start[i] > e) return ST_OK;
      le = tbl_end[i];
      if (tbl_start[i] < s) begin
        if (!split_entry(i, s)) return ST_FULL;
        if (le <= e) begin
          gone |= strip_entry(i + 1, b);
          if (le == ADDR_TOP) return ST_OK;
          s = le + 64'd1;
        end
      end else if (le > e) begin
        if (!split_entry(i, e + 64'd1)) return ST_FULL;
        gone |= strip_entry(i, b);
        return ST_OK;
      end else begin
        gone |= strip_entry(i, b);
        if (le == ADDR_TOP) return ST_OK;
        s = le + 64'd1;
      end
      if (s > e) return ST_OK;
    end
    return ST_OK;
  endfunction

  function automatic logic test_range(addr_t s_in, addr_t e, flags_t b, logic full);
    int i;
    addr_t s;
    logic hit;
    s = s_in;
    i = find_slot(s);
    hit = 0;
    while (i < tbl_count && s <= e) begin
      if (full && tbl_start[i] > s) return 0;
      if (tbl_start[i] > e) break;
      if ((tbl_flags[i] & b) != 0) begin
        hit = 1;
        if (!full) break;
      end else if (full) begin
        return 0;
      end
      if (tbl_end[i] == ADDR_TOP) break;
      s = tbl_end[i] + 64'd1;
      if (s > e) break;
      i++;
      if (i == tbl_count) return full ? 1'b0 : hit;
    end
    return hit;
  endfunction

  function automatic res_t predict_word(req_t q);
    res_t r;
    int i;
    flags_t gone;
    r = '0;
    gone = '0;
    case (q.req_type)
      OP_SET: begin
        if (q.range_end >= q.range_start)
          r.status = set_range(q.range_start, q.range_end, q.flag_mask);
      end
      OP_CLEAR: begin
        if (q.range_end >= q.range_start)
          r.status = clear_range(q.range_start, q.range_end, q.flag_mask, gone);
        r.cleared_flags = gone;
      end
      OP_TEST: begin
        r.hit = test_range(q.range_start, q.range_end, q.flag_mask, q.need_full);
      end
      OP_FIND: begin
        r.status = ST_NO_MATCH;
        for (i = find_slot(q.range_start); i < tbl_count; i++) begin
          if ((tbl_flags[i] & q.flag_mask) != 0) begin
            r.status = ST_OK;
            r.hit = 1;
            r.found_start = tbl_start[i];
            r.found_end = tbl_end[i];
            break;
          end
        end
      end
      OP_SET_PRIV, OP_GET_PRIV: begin
        i = find_slot(q.range_start);
        if (i == tbl_count || tbl_start[i] != q.range_start) r.status = ST_NO_MATCH;
        else if (q.req_type == OP_SET_PRIV) tbl_priv[i] = q.private_in;
        else r.private_out = tbl_priv[i];
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    req_t q;
    res_t got;
    res_t want;
    if (!rst_n) begin
      tbl_count = 0;
      merge_block = '0;
      expected_words.delete();
      fail_count <= 0;
      mismatches = 0;
    end else begin
      if (cfg_we) merge_block = cfg_wdata;
      if (in_ch.valid && in_ch.ready) begin
        q.req_type    = in_ch.req_type;
        q.range_start = in_ch.range_start;
        q.range_end   = in_ch.range_end;
        q.flag_mask   = in_ch.flag_mask;
        q.need_full   = in_ch.need_full;
        q.private_in  = in_ch.private_in;
        expected_words.push_back(predict_word(q));
      end
      if (out_ch.valid && out_ch.ready) begin
        got.status        = out_ch.status;
        got.hit           = out_ch.hit;
        got.found_start   = out_ch.found_start;
        got.found_end     = out_ch.found_end;
        got.cleared_flags = out_ch.cleared_flags;
        got.private_out   = out_ch.private_out;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: result word with none expected: %p", got);
        end else begin
          want = expected_words.pop_front();
          if (got.status !== want.status || got.hit !== want.hit ||
              got.found_start !== want.found_start || got.found_end !== want.found_end ||
              got.cleared_flags !== want.cleared_flags ||
              got.private_out !== want.private_out) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: word mismatch at %0t", $realtime);
              $display("  status   exp %0d got %0d", want.status, got.status);
              $display("  hit      exp %0d got %0d", want.hit, got.hit);
              $display("  found    exp %h..%h got %h..%h", want.found_start, want.found_end,
                       got.found_start, got.found_end);
              $display("  cleared  exp %h got %h", want.cleared_flags, got.cleared_flags);
              $display("  private  exp %h got %h", want.private_out, got.private_out);
            end
          end
        end
      end
      fail_count <= mismatches;
    end
    pending <= expected_words.size();
  end

endmodule

// ===== tb/tb_range_attribute_interval_map_core.sv =====
// Top of the interval map testbench: clock, reset, stimulus, receiver stalls and verdict.
module tb_range_attribute_interval_map_core;
  timeunit 1ns;
  timeprecision 1ps;
  import raim_pkg::*;

  localparam int IDLE_LIMIT = 300000;
  localparam addr_t ADDR_TOP = '1;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          fail_count;
  int          pending;
  int          idle_cycles;
  bit          quiet;
  bit          hold_request;

  raim_in_if  in_ch ();
  raim_out_if out_ch ();

  range_attribute_interval_map_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  range_attribute_interval_map_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("range_attribute_interval_map_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 0;
        out_ch.ready <= 1'b0;
        repeat (600) @(posedge clk);
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  task automatic send_word(req_t q);
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= q.req_type;
    in_ch.range_start <= q.range_start;
    in_ch.range_end   <= q.range_end;
    in_ch.flag_mask   <= q.flag_mask;
    in_ch.need_full   <= q.need_full;
    in_ch.private_in  <= q.private_in;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic issue(logic [2:0] op, addr_t s, addr_t e, flags_t m, logic full, addr_t p);
    req_t q;
    q.req_type = op;
    q.range_start = s;
    q.range_end = e;
    q.flag_mask = m;
    q.need_full = full;
    q.private_in = p;
    send_word(q);
  endtask

  task automatic write_mask(logic [15:0] m);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic addr_t rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic req_t random_word();
    req_t q;
    addr_t base;
    int pick;
    pick = $urandom_range(0, 99);
    base = (pick < 15) ? ADDR_TOP - 64'd150 : 64'd0;
    q.range_start = base + $urandom_range(0, 150);
    q.range_end = q.range_start + $urandom_range(0, 12);
    if (base != 0 && q.range_end < q.range_start) q.range_end = ADDR_TOP;
    if (pick >= 15 && pick < 20) q.range_end = ADDR_TOP;
    if (pick >= 20 && pick < 24) q.range_end = q.range_start - $urandom_range(1, 5);
    if (pick >= 24 && pick < 27) begin
      q.range_start = rand64();
      q.range_end = rand64();
    end
    pick = $urandom_range(0, 99);
    if (pick < 32) q.req_type = OP_SET;
    else if (pick < 50) q.req_type = OP_CLEAR;
    else if (pick < 64) q.req_type = OP_TEST;
    else if (pick < 76) q.req_type = OP_FIND;
    else if (pick < 86) q.req_type = OP_SET_PRIV;
    else if (pick < 96) q.req_type = OP_GET_PRIV;
    else q.req_type = 3'($urandom_range(6, 7));
    if (q.req_type == OP_CLEAR && $urandom_range(0, 9) == 0) begin
      q.range_start = 0;
      q.range_end = ADDR_TOP;
    end
    q.flag_mask = ($urandom_range(0, 1) != 0) ? flags_t'(1 << $urandom_range(0, 15))
                                              : flags_t'($urandom);
    q.need_full = 1'($urandom_range(0, 1));
    q.private_in = rand64();
    return q;
  endfunction

  initial begin
    logic [15:0] masks [5];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.req_type = '0;
    in_ch.range_start = '0;
    in_ch.range_end = '0;
    in_ch.flag_mask = '0;
    in_ch.need_full = 1'b0;
    in_ch.private_in = '0;
    quiet = 0;
    hold_request = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_mask(16'h0000);
    issue(OP_FIND, 0, 0, 16'hFFFF, 0, 0);
    issue(OP_GET_PRIV, 0, 0, 0, 0, 0);
    issue(OP_SET, 10, 20, 16'h0001, 0, 0);
    issue(OP_SET, 15, 30, 16'h0002, 0, 0);
    issue(OP_SET, 12, 13, 16'h0004, 0, 0);
    issue(OP_SET, 0, ADDR_TOP, 16'h8000, 0, 0);
    issue(OP_TEST, 0, ADDR_TOP, 16'h8000, 1, 0);
    issue(OP_TEST, 5, 40, 16'h0002, 1, 0);
    issue(OP_TEST, 5, 40, 16'h0002, 0, 0);
    issue(OP_SET_PRIV, 0, 0, 0, 0, ADDR_TOP);
    issue(OP_GET_PRIV, 0, 0, 0, 0, 0);
    issue(OP_SET_PRIV, 15, 0, 0, 0, 64'h5A5A_A5A5_0123_4567);
    issue(OP_GET_PRIV, 15, 0, 0, 0, 0);
    issue(OP_FIND, 11, 0, 16'h0002, 0, 0);
    issue(OP_SET, 30, 10, 16'h0010, 0, 0);
    issue(OP_CLEAR, 30, 10, 16'hFFFF, 0, 0);
    issue(OP_TEST, 30, 10, 16'hFFFF, 0, 0);
    issue(3'd6, 1, 2, 16'hFFFF, 1, ADDR_TOP);
    issue(3'd7, ADDR_TOP, ADDR_TOP, 16'hFFFF, 1, ADDR_TOP);
    issue(OP_CLEAR, 14, 16, 16'h8003, 0, 0);
    issue(OP_FIND, ADDR_TOP, 0, 16'h8000, 0, 0);
    issue(OP_CLEAR, 0, ADDR_TOP, 16'hFFFF, 0, 0);
    issue(OP_TEST, ADDR_TOP, ADDR_TOP, 16'hFFFF, 1, 0);

    masks[0] = 16'hFFFF;
    masks[1] = 16'h0000;
    masks[2] = 16'($urandom);
    masks[3] = 16'h00F0;
    masks[4] = 16'($urandom);
    for (int ph = 0; ph < 5; ph++) begin
      write_mask(masks[ph]);
      if (ph == 4) quiet = 1;
      for (int n = 0; n < 200; n++) begin
        if (ph == 1 && n == 20) hold_request = 1;
        if (ph == 0 && n < 70) issue(OP_SET, addr_t'(n * 2), addr_t'(n * 2),
                                     flags_t'(1 << (n % 16)), 0, 0);
        else send_word(random_word());
      end
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("range_attribute_interval_map_core verification clean");
    end else begin
      $display("range_attribute_interval_map_core verification failed");
    end
    $finish;
  end

endmodule

// ===== range_attribute_interval_map_core.f =====
rtl/core/raim_pkg.sv
rtl/core/raim_if.sv
rtl/core/raim_ram.sv
rtl/core/raim_engine.sv
rtl/core/range_attribute_interval_map_core.sv
rtl/core/raim_checker.sv
tb/range_attribute_interval_map_checker.sv
tb/tb_range_attribute_interval_map_core.sv
